>>> sv/assert_macros.svh
// Assertion macros shared by the frame receiver modules sfr_in_stage and sfr_core.
// No dependencies; each user supplies its own clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, off while reset is low.
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// Check that a condition never holds at a rising clock edge.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	`ASSERT_PROP(label, clk, rst_n, !(cond))

`endif

>>> sv/sfr_pkg.sv
// Types, constants and the CRC-16/Modbus byte update for the frame receiver.
// No dependencies.
package sfr_pkg;

	localparam logic [7:0]  START_RESET = 8'hAA;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [7:0]  MIN_LEN     = 8'd3;
	localparam logic [7:0]  CRC_BYTES   = 8'd2;

	// Input request: a received byte or a read timeout
	typedef enum logic {
		ACT_BYTE    = 1'b0,
		ACT_TIMEOUT = 1'b1
	} action_t;

	// Result codes
	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_GOOD  = 2'd1,
		KIND_BAD   = 2'd2,
		KIND_ABORT = 2'd3
	} kind_t;

	// Receiver phase
	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_LEN  = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] rx_byte;
	} sfr_in_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
	} sfr_out_t;

	// Result of one processed request, from the core to the output stage
	typedef struct packed {
		logic     valid;
		sfr_out_t data;
	} sfr_res_t;

	// Fold one byte into a reflected CRC-16 (poly 0xA001), LSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> sv/sfr_in_stage.sv
// Input register of the frame receiver: holds one request until the core takes it.
// Depends on sfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfr_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sfr_pkg::sfr_in_t in_data,
	input  logic            advance,
	output logic            valid_s1,
	output sfr_pkg::sfr_in_t data_s1
);
	import sfr_pkg::*;

	// Take a new request when empty or when the held one moves on
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload needs no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	// A held request that is not consumed stays put
	`ASSERT_PROP(a_hold_s1, clk, arst_n,
		(valid_s1 && !advance) |=> (valid_s1 && $stable(data_s1)))

endmodule

>>> sv/sfr_core.sv
// Deframer state and CRC check: turns one request into zero or one result.
// Depends on sfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfr_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_wdata,
	input  logic             step,
	input  sfr_pkg::sfr_in_t item,
	output sfr_pkg::sfr_res_t res
);
	import sfr_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  start_marker_q;
	logic [7:0]  bytes_left_q, bytes_left_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_lo_q, crc_lo_d;
	logic [7:0]  count_q, count_d;
	logic        is_timeout;
	logic [7:0]  b;

	assign is_timeout = (item.action == ACT_TIMEOUT);
	assign b          = item.rx_byte;

	// Start marker register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_RESET;
		end else if (cfg_we) begin
			start_marker_q <= cfg_wdata;
		end
	end

	// Next phase
	always_comb begin
		phase_d = PH_HUNT;
		unique case (phase_q)
			PH_LEN: begin
				phase_d = (is_timeout || b < MIN_LEN) ? PH_HUNT : PH_BODY;
			end
			PH_BODY: begin
				phase_d = (!is_timeout && bytes_left_q >= CRC_BYTES) ? PH_BODY : PH_HUNT;
			end
			default: begin
				phase_d = (!is_timeout && b == start_marker_q) ? PH_LEN : PH_HUNT;
			end
		endcase
	end

	// Counters, CRC and result
	always_comb begin
		bytes_left_d = 8'd0;
		crc_d        = CRC_INIT;
		crc_lo_d     = 8'd0;
		count_d      = 8'd0;
		res          = '0;
		res.data.kind = KIND_DATA;
		unique case (phase_q)
			PH_LEN: begin
				if (!is_timeout && b >= MIN_LEN) begin
					bytes_left_d = b - 8'd1;
					crc_d        = crc16_byte(CRC_INIT, b);
				end
			end
			PH_BODY: begin
				if (is_timeout) begin
					res.valid              = 1'b1;
					res.data.kind          = KIND_ABORT;
					res.data.payload_index = count_q;
				end else if (bytes_left_q > CRC_BYTES) begin
					// Payload byte: pass on, fold into CRC
					bytes_left_d           = bytes_left_q - 8'd1;
					crc_d                  = crc16_byte(crc_q, b);
					count_d                = count_q + 8'd1;
					res.valid              = 1'b1;
					res.data.kind          = KIND_DATA;
					res.data.payload_byte  = b;
					res.data.payload_index = count_q;
				end else if (bytes_left_q == CRC_BYTES) begin
					// Low CRC byte: hold it
					bytes_left_d = 8'd1;
					crc_d        = crc_q;
					crc_lo_d     = b;
					count_d      = count_q;
				end else begin
					// High CRC byte: give the verdict
					res.valid              = 1'b1;
					res.data.kind          = ({b, crc_lo_q} == crc_q) ? KIND_GOOD : KIND_BAD;
					res.data.payload_index = count_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			bytes_left_q <= 8'd0;
			crc_q        <= CRC_INIT;
			crc_lo_q     <= 8'd0;
			count_q      <= 8'd0;
		end else if (step) begin
			phase_q      <= phase_d;
			bytes_left_q <= bytes_left_d;
			crc_q        <= crc_d;
			crc_lo_q     <= crc_lo_d;
			count_q      <= count_d;
		end
	end

	// A verdict always sends the receiver back to hunting
	`ASSERT_PROP(a_verdict_hunt, clk, arst_n,
		(step && res.valid && res.data.kind != KIND_DATA) |=> (phase_q == PH_HUNT))
	// Payload bytes come only from the frame body with payload still due
	`ASSERT_PROP(a_data_in_body, clk, arst_n,
		(res.valid && res.data.kind == KIND_DATA) |->
			(phase_q == PH_BODY && bytes_left_q > CRC_BYTES))
	// The body never runs out of bytes without a verdict
	`ASSERT_NEVER(a_body_left, clk, arst_n,
		phase_q == PH_BODY && bytes_left_q == 8'd0)

endmodule

>>> sv/sfr_out_stage.sv
// Output register of the frame receiver: holds one result until it is taken.
// Depends on sfr_pkg.
module sfr_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  sfr_pkg::sfr_res_t res,
	output logic              free,
	output logic              out_valid,
	input  logic              out_ready,
	output sfr_pkg::sfr_out_t out_data
);
	import sfr_pkg::*;

	logic valid_q;

	// Room for a result when empty or when the held one is being taken
	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= res.valid;
		end
	end

	// Load payload with each new result
	always_ff @(posedge clk) begin
		if (free && res.valid) begin
			out_data <= res.data;
		end
	end

endmodule

>>> sv/serial_frame_receiver_crc16_unit.sv
// Serial frame receiver with CRC-16/Modbus check, top level.
// Depends on sfr_pkg, sfr_in_stage, sfr_core, sfr_out_stage.
// Usage:
//   in_valid/in_ready/in_data carry one request: a received byte or a read
//   timeout. out_valid/out_ready/out_data carry results: payload bytes with
//   their index, and one verdict (good, CRC mismatch, timeout abort) per frame.
//   cfg_we/cfg_wdata write the start marker; write it only while idle.
//   Frames are [start] [len] [payload] [crc_lo] [crc_hi], len counting itself,
//   the payload and the CRC bytes; CRC covers the length byte and payload.
// Timing:
//   Throughput is one request per cycle while the result register has room; the
//   CRC byte update is a single combinational step between the input register
//   and the result register, which takes the result once it has room.
// Reset:
//   arst_n clears both stages, sets the hunting phase and CRC 0xFFFF, and
//   loads the start marker with 0xAA.
// Stall:
//   With out_ready low the result is held; one more request is still taken
//   into the input register, after which in_ready drops until room opens.
module serial_frame_receiver_crc16_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sfr_pkg::sfr_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output sfr_pkg::sfr_out_t out_data,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata
);
	import sfr_pkg::*;

	logic      valid_s1;
	sfr_in_t   data_s1;
	logic      out_free;
	sfr_res_t  res;
	sfr_res_t  res_gated;

	// Qualify the core result with a held request
	assign res_gated = {res.valid && valid_s1, res.data};

	sfr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.advance  (out_free),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	sfr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (valid_s1 && out_free),
		.item      (data_s1),
		.res       (res)
	);

	sfr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res_gated),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

>>> test/tb.sv
// Testbench for serial_frame_receiver_crc16_unit: CRC-16/Modbus frames, short lengths,
// timeouts and start marker settings are sent and each result is checked against a predictor.
// Depends on sfr_pkg and the serial_frame_receiver_crc16_unit RTL.
`timescale 1ns / 100ps

module tb;
	import sfr_pkg::*;

	localparam int          LATENCY_PAD     = 6;
	localparam int          STALL_LIMIT     = 2000;
	localparam logic [15:0] MODBUS_SEED     = 16'hFFFF;
	localparam logic [15:0] MODBUS_POLY     = 16'hA001;
	localparam logic [7:0]  MARKER_AT_RESET = 8'hAA;
	localparam logic [7:0]  SHORTEST_LEN    = 8'd3;

	typedef enum int {
		FATE_INTACT,
		FATE_CORRUPT,
		FATE_CUT
	} frame_fate_t;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	sfr_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	sfr_out_t out_data;
	logic     cfg_we;
	logic [7:0] cfg_wdata;

	// Receiver state as the testbench sees it
	phase_t      rx_phase;
	logic [7:0]  rx_left;
	logic [15:0] rx_crc;
	logic [7:0]  rx_crc_lo;
	logic [7:0]  rx_count;
	logic [7:0]  rx_marker;

	sfr_out_t due_results[$];
	int       mismatches    = 0;
	int       requests_sent = 0;
	int       quiet         = 0;
	bit       tx_steady     = 1'b0;

	serial_frame_receiver_crc16_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Fold one byte into the reflected CRC, low bit first
	function automatic logic [15:0] crc_modbus_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc;
		c[7:0] = c[7:0] ^ b;
		repeat (8) c = {1'b0, c[15:1]} ^ (c[0] ? MODBUS_POLY : 16'h0000);
		return c;
	endfunction

	// Drop any frame in progress and return to hunting
	function automatic void rx_hunt();
		rx_phase  = PH_HUNT;
		rx_left   = 8'd0;
		rx_crc    = MODBUS_SEED;
		rx_crc_lo = 8'd0;
		rx_count  = 8'd0;
	endfunction

	// Append one result to the due list
	function automatic void add_due(input sfr_out_t r);
		due_results = {due_results, r};
	endfunction

	// Advance the receiver state by one request and queue the result it causes
	function automatic void rx_predict(input sfr_in_t r);
		logic       quit;
		logic [7:0] b;
		quit = (r.action == ACT_TIMEOUT);
		b = r.rx_byte;
		case (rx_phase)
			PH_LEN: begin
				if (quit || b < SHORTEST_LEN) begin
					rx_hunt();
				end else begin
					rx_left   = b - 8'd1;
					rx_crc    = crc_modbus_step(MODBUS_SEED, b);
					rx_count  = 8'd0;
					rx_crc_lo = 8'd0;
					rx_phase  = PH_BODY;
				end
			end
			PH_BODY: begin
				if (quit) begin
					add_due(sfr_out_t'{KIND_ABORT, 8'h00, rx_count});
					rx_hunt();
				end else if (rx_left > 8'd2) begin
					add_due(sfr_out_t'{KIND_DATA, b, rx_count});
					rx_crc   = crc_modbus_step(rx_crc, b);
					rx_count = rx_count + 8'd1;
					rx_left  = rx_left - 8'd1;
				end else if (rx_left == 8'd2) begin
					rx_crc_lo = b;
					rx_left   = 8'd1;
				end else begin
					add_due(sfr_out_t'{
						({b, rx_crc_lo} == rx_crc) ? KIND_GOOD : KIND_BAD, 8'h00, rx_count});
					rx_hunt();
				end
			end
			default: begin
				rx_hunt();
				if (!quit && b == rx_marker)
					rx_phase = PH_LEN;
			end
		endcase
	endfunction

	// Mostly back-to-back, sometimes a short pause, rarely a long one
	function automatic int pick_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (tx_steady || pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	// Mostly short payloads, a few long ones
	function automatic int payload_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			return $urandom_range(0, 6);
		if (pick < 98)
			return $urandom_range(7, 30);
		return $urandom_range(31, 252);
	endfunction

	// Offer one request and hold it until accepted; valid stays high afterwards
	task automatic push_request(input sfr_in_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		rx_predict(r);
		requests_sent++;
		if ($urandom_range(0, 63) == 0)
			tx_steady = !tx_steady;
	endtask

	task automatic send_byte(input logic [7:0] b);
		sfr_in_t r;
		r.action  = ACT_BYTE;
		r.rx_byte = b;
		push_request(r);
	endtask

	task automatic send_timeout();
		sfr_in_t r;
		r.action  = ACT_TIMEOUT;
		r.rx_byte = 8'($urandom);
		push_request(r);
	endtask

	// Send one frame with n random payload bytes: intact, with a corrupted CRC, or cut short by a timeout
	task automatic send_frame(input int n, input frame_fate_t fate);
		logic [15:0] crc;
		logic [7:0]  b;
		int          cut;
		cut = (fate == FATE_CUT) ? $urandom_range(0, n + 1) : -1;
		send_byte(rx_marker);
		send_byte(8'(n + 3));
		crc = crc_modbus_step(MODBUS_SEED, 8'(n + 3));
		for (int i = 0; i < n; i++) begin
			if (i == cut) begin
				send_timeout();
				return;
			end
			b = 8'($urandom);
			crc = crc_modbus_step(crc, b);
			send_byte(b);
		end
		if (fate == FATE_CORRUPT)
			crc = crc ^ (16'h0001 << $urandom_range(0, 15));
		if (cut == n) begin
			send_timeout();
			return;
		end
		send_byte(crc[7:0]);
		if (cut == n + 1) begin
			send_timeout();
			return;
		end
		send_byte(crc[15:8]);
	endtask

	// Drop valid, wait for every due result, then let the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (LATENCY_PAD) @(posedge clk);
	endtask

	task automatic set_marker(input logic [7:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		rx_marker = v;
	endtask

	// Random frames of every fate mixed with noise; only frame requests count toward quota
	task automatic random_traffic(input int quota);
		int framed;
		int mark;
		int pick;
		framed = 0;
		while (framed < quota) begin
			pick = $urandom_range(0, 99);
			mark = requests_sent;
			if (pick < 62) begin
				send_frame(payload_len(), FATE_INTACT);
			end else if (pick < 74) begin
				send_frame(payload_len(), FATE_CORRUPT);
			end else if (pick < 84) begin
				send_frame(payload_len(), FATE_CUT);
			end else if (pick < 89) begin
				send_byte(rx_marker);
				send_byte(8'($urandom_range(0, 2)));
			end else if (pick < 95) begin
				send_byte(8'($urandom));
			end else begin
				send_timeout();
			end
			if (pick < 89)
				framed += requests_sent - mark;
		end
	endtask

	task automatic test_edge_frames();
		logic [15:0] crc;
		// empty payload, CRC over the length byte only
		send_frame(0, FATE_INTACT);
		// extreme payload bytes with a wrong CRC low byte
		crc = crc_modbus_step(crc_modbus_step(crc_modbus_step(MODBUS_SEED, 8'd5), 8'h00), 8'hFF);
		send_byte(rx_marker);
		send_byte(8'd5);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(~crc[7:0]);
		send_byte(crc[15:8]);
		// lengths below the minimum are dropped
		send_byte(rx_marker);
		send_byte(8'd0);
		send_byte(rx_marker);
		send_byte(8'd2);
		// timeout while hunting, then while awaiting the length
		send_timeout();
		send_byte(rx_marker);
		send_timeout();
		// timeout in the body after one payload byte
		send_byte(rx_marker);
		send_byte(8'd6);
		send_byte(8'h3C);
		send_timeout();
		// a length equal to the start marker is still a length
		send_byte(rx_marker);
		send_byte(rx_marker);
		send_byte(8'h81);
		send_timeout();
	endtask

	task automatic test_longest_frame();
		send_frame(252, FATE_INTACT);
		send_frame(252, FATE_CUT);
	endtask

	task automatic test_marker_values();
		set_marker(8'h00);
		random_traffic(40);
		set_marker(8'hFF);
		random_traffic(40);
		// a dropped length byte equal to the marker does not open a frame
		set_marker(8'h01);
		send_byte(8'h01);
		send_byte(8'h01);
		send_frame(2, FATE_INTACT);
		random_traffic(40);
		// marker equal to the shortest length: the frame's length byte repeats it
		set_marker(SHORTEST_LEN);
		send_frame(0, FATE_INTACT);
		random_traffic(40);
		set_marker(8'($urandom));
		random_traffic(40);
		set_marker(MARKER_AT_RESET);
	endtask

	task automatic test_random_traffic();
		random_traffic(200);
	endtask

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= 8'h00;
		rx_marker = MARKER_AT_RESET;
		rx_hunt();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edge_frames();
		test_longest_frame();
		test_marker_values();
		test_random_traffic();
		drain();

		if (mismatches == 0)
			$display("PASS serial_frame_receiver_crc16_unit");
		else
			$display("FAIL serial_frame_receiver_crc16_unit");
		$finish;
	end

	// Result side: ready in runs, stalls mostly short, now and then long
	initial begin
		int run;
		int stall;
		int pick;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			run = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 150) : $urandom_range(1, 6);
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			pick = $urandom_range(0, 99);
			if (pick < 60)
				stall = $urandom_range(1, 2);
			else if (pick < 92)
				stall = $urandom_range(3, 6);
			else
				stall = $urandom_range(10, 40);
			out_ready <= 1'b0;
			repeat (stall) @(posedge clk);
		end
	end

	// Compare each accepted result with the oldest due one
	always @(posedge clk) begin
		sfr_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				$error("result with nothing due: kind %0d byte %0h index %0d",
					out_data.kind, out_data.payload_byte, out_data.payload_index);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				if (out_data.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, out_data.kind);
					mismatches++;
				end
				if (out_data.payload_byte !== want.payload_byte) begin
					$error("payload_byte: expected %0h, got %0h",
						want.payload_byte, out_data.payload_byte);
					mismatches++;
				end
				if (out_data.payload_index !== want.payload_index) begin
					$error("payload_index: expected %0d, got %0d",
						want.payload_index, out_data.payload_index);
					mismatches++;
				end
			end
		end
	end

	// Stop the run if nothing moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else if (quiet == STALL_LIMIT) begin
			$display("FAIL serial_frame_receiver_crc16_unit");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

endmodule

>>> filelist.f
+incdir+sv
sv/sfr_pkg.sv
sv/sfr_in_stage.sv
sv/sfr_core.sv
sv/sfr_out_stage.sv
sv/serial_frame_receiver_crc16_unit.sv
test/tb.sv
